// ===== rtl/owtm_pkg.sv =====
`timescale 1ns / 1ps

package owtm_pkg;

  // Item kinds on the command channel.
  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_RESET = 2'd1;
  localparam logic [1:0] KIND_WRITE = 2'd2;
  localparam logic [1:0] KIND_READ  = 2'd3;

  // Line drive codes on the result channel.
  localparam logic [1:0] DRIVE_RELEASED = 2'd0;
  localparam logic [1:0] DRIVE_LOW      = 2'd1;
  localparam logic [1:0] DRIVE_HIGH     = 2'd2;

  // Width of the microsecond wait countdown.
  localparam int WAIT_W = 9;

  // Bus timing in microsecond ticks.
  localparam logic [WAIT_W-1:0] WAIT_RST_HIGH  = 9'd3;
  localparam logic [WAIT_W-1:0] WAIT_RST_LOW   = 9'd480;
  localparam logic [WAIT_W-1:0] WAIT_RST_SETTLE = 9'd70;
  localparam logic [WAIT_W-1:0] WAIT_RST_TAIL  = 9'd410;
  localparam logic [WAIT_W-1:0] WAIT_SLOT_LOW  = 9'd4;
  localparam logic [WAIT_W-1:0] WAIT_WR_DATA   = 9'd54;
  localparam logic [WAIT_W-1:0] WAIT_WR_RECOV  = 9'd10;
  localparam logic [WAIT_W-1:0] WAIT_RD_SAMPLE = 9'd6;
  localparam logic [WAIT_W-1:0] WAIT_RD_TAIL   = 9'd60;

  // Mask values that open a byte transfer.
  localparam logic [7:0] MASK_LSB = 8'h01;
  localparam logic [7:0] MASK_MSB = 8'h80;

  typedef enum logic [1:0] {
    ST_NOT_READY = 2'd0,
    ST_READY     = 2'd1,
    ST_BUSY      = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    PH_IDLE = 4'd0,
    PH_RST0 = 4'd1,
    PH_RST1 = 4'd2,
    PH_RST2 = 4'd3,
    PH_RST3 = 4'd4,
    PH_WR0  = 4'd5,
    PH_WR1  = 4'd6,
    PH_WR2  = 4'd7,
    PH_WR3  = 4'd8,
    PH_RD0  = 4'd9,
    PH_RD1  = 4'd10,
    PH_RD2  = 4'd11,
    PH_RD3  = 4'd12
  } phase_t;

endpackage

// ===== rtl/owtm_if.sv =====
`timescale 1ns / 1ps

// Command channel: one tick or start command per word.
interface owtm_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] write_byte;
  logic       line_level;

  modport source (output valid, kind, write_byte, line_level, input ready);
  modport sink (input valid, kind, write_byte, line_level, output ready);
endinterface

// Result channel: one result word per command word.
interface owtm_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] line_drive;
  logic [1:0] status;
  logic       accepted;
  logic       device_present;
  logic [7:0] read_byte;

  modport source (output valid, line_drive, status, accepted, device_present, read_byte,
                  input ready);
  modport sink (input valid, line_drive, status, accepted, device_present, read_byte,
                output ready);
endinterface

// ===== rtl/onewire_tick_driven_master.sv =====
// Latency: a result word appears in the cycle after its command word is taken.
// Throughput: one word per clock; the one-word result register lets a new word
// in whenever it is empty or being drained in the same cycle.
// Reset (rst, synchronous, active high): sequencer idle, no wait, line released,
// status not yet ready, no presence, read byte zero, result register empty.
`timescale 1ns / 1ps

module onewire_tick_driven_master
  import owtm_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  owtm_cmd_if.sink     cmd,
  owtm_res_if.source   res
);

  // Sequencer state.
  phase_t            phase, phase_next;
  logic [WAIT_W-1:0] wait_count, wait_count_next;
  logic [7:0]        shift_byte, shift_byte_next;
  logic [7:0]        bit_mask, bit_mask_next;
  logic              presence_sample, presence_sample_next;
  status_t           status_reg, status_reg_next;
  logic              pin_is_output, pin_is_output_next;
  logic              pin_level, pin_level_next;
  logic [7:0]        last_read, last_read_next;
  logic              acc_next;
  logic              run_step;
  logic [7:0]        shifted_mask;

  // Result register.
  logic              res_valid;
  logic [1:0]        res_drive;
  logic [1:0]        res_status;
  logic              res_accepted;
  logic              res_present;
  logic [7:0]        res_read;

  logic              cmd_take;

  assign cmd.ready = !res_valid || res.ready;
  assign cmd_take  = cmd.valid && cmd.ready;

  // One step of the sequencer for the word on the command channel.
  always_comb begin
    phase_next           = phase;
    wait_count_next      = wait_count;
    shift_byte_next      = shift_byte;
    bit_mask_next        = bit_mask;
    presence_sample_next = presence_sample;
    status_reg_next      = status_reg;
    pin_is_output_next   = pin_is_output;
    pin_level_next       = pin_level;
    last_read_next       = last_read;
    acc_next             = 1'b0;
    run_step             = 1'b1;
    shifted_mask         = {bit_mask[6:0], 1'b0};

    if (cmd.kind == KIND_TICK) begin
      // A pending wait counts down; the action runs on the tick that ends it.
      if (wait_count != '0) begin
        wait_count_next = wait_count - 1'b1;
        run_step        = (wait_count == {{(WAIT_W-1){1'b0}}, 1'b1});
      end
      if (run_step) begin
        unique case (phase)
          PH_IDLE: begin
            status_reg_next = ST_READY;
          end
          PH_RST0: begin
            pin_is_output_next = 1'b1;
            pin_level_next     = 1'b0;
            wait_count_next    = WAIT_RST_LOW;
            phase_next         = PH_RST1;
          end
          PH_RST1: begin
            pin_is_output_next = 1'b0;
            wait_count_next    = WAIT_RST_SETTLE;
            phase_next         = PH_RST2;
          end
          PH_RST2: begin
            presence_sample_next = !cmd.line_level;
            wait_count_next      = WAIT_RST_TAIL;
            phase_next           = PH_RST3;
          end
          PH_RST3: begin
            phase_next      = PH_IDLE;
            status_reg_next = ST_READY;
          end
          PH_WR0: begin
            pin_is_output_next = 1'b1;
            pin_level_next     = 1'b0;
            wait_count_next    = WAIT_SLOT_LOW;
            phase_next         = PH_WR1;
          end
          PH_WR1: begin
            if ((shift_byte & bit_mask) != 8'h00) begin
              pin_is_output_next = 1'b0;
            end
            wait_count_next = WAIT_WR_DATA;
            phase_next      = PH_WR2;
          end
          PH_WR2: begin
            pin_is_output_next = 1'b0;
            wait_count_next    = WAIT_WR_RECOV;
            bit_mask_next      = shifted_mask;
            phase_next         = (shifted_mask != 8'h00) ? PH_WR0 : PH_WR3;
          end
          PH_WR3: begin
            phase_next      = PH_IDLE;
            status_reg_next = ST_READY;
          end
          PH_RD0: begin
            pin_is_output_next = 1'b1;
            pin_level_next     = 1'b0;
            wait_count_next    = WAIT_SLOT_LOW;
            phase_next         = PH_RD1;
          end
          PH_RD1: begin
            pin_is_output_next = 1'b0;
            wait_count_next    = WAIT_RD_SAMPLE;
            phase_next         = PH_RD2;
          end
          PH_RD2: begin
            shift_byte_next = {cmd.line_level, shift_byte[7:1]};
            wait_count_next = WAIT_RD_TAIL;
            phase_next      = PH_RD3;
          end
          PH_RD3: begin
            bit_mask_next = {1'b0, bit_mask[7:1]};
            if (bit_mask[7:1] != 7'd0) begin
              phase_next = PH_RD0;
            end else begin
              last_read_next  = shift_byte;
              phase_next      = PH_IDLE;
              status_reg_next = ST_READY;
            end
          end
          default: begin
            phase_next = PH_IDLE;
          end
        endcase
      end
    end else if (status_reg != ST_BUSY) begin
      // Start command; refused without any change while busy.
      acc_next        = 1'b1;
      status_reg_next = ST_BUSY;
      if (cmd.kind == KIND_RESET) begin
        pin_is_output_next   = 1'b1;
        pin_level_next       = 1'b1;
        wait_count_next      = WAIT_RST_HIGH;
        presence_sample_next = 1'b0;
        phase_next           = PH_RST0;
      end else if (cmd.kind == KIND_WRITE) begin
        bit_mask_next   = MASK_LSB;
        shift_byte_next = cmd.write_byte;
        phase_next      = PH_WR0;
      end else begin
        shift_byte_next = 8'h00;
        bit_mask_next   = MASK_MSB;
        phase_next      = PH_RD0;
      end
    end
  end

  // State registers advance only on an accepted word.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      wait_count      <= '0;
      shift_byte      <= 8'h00;
      bit_mask        <= 8'h00;
      presence_sample <= 1'b0;
      status_reg      <= ST_NOT_READY;
      pin_is_output   <= 1'b0;
      pin_level       <= 1'b1;
      last_read       <= 8'h00;
    end else if (cmd_take) begin
      phase           <= phase_next;
      wait_count      <= wait_count_next;
      shift_byte      <= shift_byte_next;
      bit_mask        <= bit_mask_next;
      presence_sample <= presence_sample_next;
      status_reg      <= status_reg_next;
      pin_is_output   <= pin_is_output_next;
      pin_level       <= pin_level_next;
      last_read       <= last_read_next;
    end
  end

  // Result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd_take) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  // Result payload, loaded with the state left by the accepted word.
  always_ff @(posedge clk) begin
    if (cmd_take) begin
      res_drive    <= pin_is_output_next ? (pin_level_next ? DRIVE_HIGH : DRIVE_LOW)
                                         : DRIVE_RELEASED;
      res_status   <= 2'(status_reg_next);
      res_accepted <= acc_next;
      res_present  <= presence_sample_next;
      res_read     <= last_read_next;
    end
  end

  assign res.valid          = res_valid;
  assign res.line_drive     = res_drive;
  assign res.status         = res_status;
  assign res.accepted       = res_accepted;
  assign res.device_present = res_present;
  assign res.read_byte      = res_read;

endmodule

// ===== rtl/owtm_checker.sv =====
`timescale 1ns / 1ps

module owtm_assert
  import owtm_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       cmd_valid,
  input logic       cmd_ready,
  input logic [1:0] cmd_kind,
  input logic       res_valid,
  input logic       res_ready,
  input logic [1:0] res_line_drive,
  input logic [1:0] res_status,
  input logic       res_accepted
);

  // A stalled result word stays offered.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result word dropped while stalled");

  // Every accepted command word yields a result word in the next cycle.
  a_cmd_result: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> res_valid)
    else $error("no result word after an accepted command word");

  // A tick never reports a taken command.
  a_tick_not_taken: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready && cmd_kind == KIND_TICK |=> !res_accepted)
    else $error("tick reported as an accepted command");

  // An offered result word carries a legal drive code, and a taken command leaves
  // the master busy.
  a_taken_busy: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_line_drive <= DRIVE_HIGH &&
                  (!res_accepted || res_status == 2'(ST_BUSY)))
    else $error("illegal drive code or accepted command without busy status");

  // With the result register empty the block takes a word.
  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !res_valid |-> cmd_ready)
    else $error("not ready with an empty result register");

endmodule

bind onewire_tick_driven_master owtm_assert u_owtm_assert (
  .clk            (clk),
  .rst            (rst),
  .cmd_valid      (cmd.valid),
  .cmd_ready      (cmd.ready),
  .cmd_kind       (cmd.kind),
  .res_valid      (res.valid),
  .res_ready      (res.ready),
  .res_line_drive (res.line_drive),
  .res_status     (res.status),
  .res_accepted   (res.accepted)
);

// ===== tb/sv/owtm_checker.sv =====
`timescale 1ns / 1ps

// Watches the command and result channels of the 1-Wire master. It predicts each
// result word from the accepted command words and compares it with the one that arrives.
module owtm_checker
  import owtm_pkg::*;
(
  input  logic clk,
  input  logic rst,
  owtm_cmd_if  cmd,
  owtm_res_if  res,
  output int   fail_count,
  output int   outstanding
);

  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [1:0] line_drive;
    logic [1:0] status;
    logic       accepted;
    logic       device_present;
    logic [7:0] read_byte;
  } bus_result_t;

  // Predicted state of the master.
  phase_t            seq_phase;
  logic [WAIT_W-1:0] tick_wait;
  logic [7:0]        shift_q;
  logic [7:0]        bit_sel;
  logic              presence_q;
  status_t           bus_status;
  logic              pin_driven;
  logic              pin_high;
  logic [7:0]        read_q;

  bus_result_t expected_q[$];
  bus_result_t got_word;
  bus_result_t want_word;

  // Applies one command word to the predicted master and returns its result word.
  function automatic bus_result_t step_master(input logic [1:0] kind, input logic [7:0] wb,
                                              input logic lvl);
    logic       took;
    logic [1:0] drive;
    took = 1'b0;
    if (kind == KIND_TICK) begin
      // A pending wait swallows the tick unless it runs out on this one.
      if (tick_wait != '0) tick_wait = tick_wait - 1'b1;
      if (tick_wait == '0) begin
        case (seq_phase)
          PH_IDLE: bus_status = ST_READY;
          PH_RST0: begin
            pin_driven = 1'b1;
            pin_high = 1'b0;
            tick_wait = WAIT_RST_LOW;
            seq_phase = PH_RST1;
          end
          PH_RST1: begin
            pin_driven = 1'b0;
            tick_wait = WAIT_RST_SETTLE;
            seq_phase = PH_RST2;
          end
          PH_RST2: begin
            presence_q = ~lvl;
            tick_wait = WAIT_RST_TAIL;
            seq_phase = PH_RST3;
          end
          PH_RST3, PH_WR3: begin
            seq_phase = PH_IDLE;
            bus_status = ST_READY;
          end
          PH_WR0, PH_RD0: begin
            pin_driven = 1'b1;
            pin_high = 1'b0;
            tick_wait = WAIT_SLOT_LOW;
            seq_phase = (seq_phase == PH_WR0) ? PH_WR1 : PH_RD1;
          end
          PH_WR1: begin
            // A one bit lets the line go early; a zero keeps it low for the slot.
            if ((shift_q & bit_sel) != '0) pin_driven = 1'b0;
            tick_wait = WAIT_WR_DATA;
            seq_phase = PH_WR2;
          end
          PH_WR2: begin
            pin_driven = 1'b0;
            tick_wait = WAIT_WR_RECOV;
            bit_sel = bit_sel << 1;
            seq_phase = (bit_sel != '0) ? PH_WR0 : PH_WR3;
          end
          PH_RD1: begin
            pin_driven = 1'b0;
            tick_wait = WAIT_RD_SAMPLE;
            seq_phase = PH_RD2;
          end
          PH_RD2: begin
            shift_q = {lvl, shift_q[7:1]};
            tick_wait = WAIT_RD_TAIL;
            seq_phase = PH_RD3;
          end
          PH_RD3: begin
            bit_sel = bit_sel >> 1;
            if (bit_sel != '0) begin
              seq_phase = PH_RD0;
            end else begin
              read_q = shift_q;
              seq_phase = PH_IDLE;
              bus_status = ST_READY;
            end
          end
          default: seq_phase = PH_IDLE;
        endcase
      end
    end else if (bus_status != ST_BUSY) begin
      // Start commands are taken whenever the master is not busy.
      took = 1'b1;
      case (kind)
        KIND_RESET: begin
          pin_driven = 1'b1;
          pin_high = 1'b1;
          tick_wait = WAIT_RST_HIGH;
          presence_q = 1'b0;
          seq_phase = PH_RST0;
        end
        KIND_WRITE: begin
          bit_sel = MASK_LSB;
          shift_q = wb;
          seq_phase = PH_WR0;
        end
        default: begin
          shift_q = '0;
          bit_sel = MASK_MSB;
          seq_phase = PH_RD0;
        end
      endcase
      bus_status = ST_BUSY;
    end
    drive = pin_driven ? (pin_high ? DRIVE_HIGH : DRIVE_LOW) : DRIVE_RELEASED;
    return '{drive, bus_status, took, presence_q, read_q};
  endfunction

  task automatic report_word(input string what, input bus_result_t want, input bus_result_t got);
    fail_count++;
    if (fail_count <= MAX_REPORTS)
      $display("%0t %s: expected drive %0d status %0d acc %0b pres %0b byte %02h",
               $time, what, want.line_drive, want.status, want.accepted,
               want.device_present, want.read_byte,
               " / got drive %0d status %0d acc %0b pres %0b byte %02h",
               got.line_drive, got.status, got.accepted, got.device_present, got.read_byte);
  endtask

  // Compare result words against the oldest prediction, then predict the new command word.
  always @(posedge clk) begin
    if (rst) begin
      seq_phase = PH_IDLE;
      tick_wait = '0;
      shift_q = '0;
      bit_sel = '0;
      presence_q = 1'b0;
      bus_status = ST_NOT_READY;
      pin_driven = 1'b0;
      pin_high = 1'b1;
      read_q = '0;
      expected_q.delete();
      fail_count = 0;
    end else begin
      if (res.valid && res.ready) begin
        got_word = '{res.line_drive, res.status, res.accepted, res.device_present,
                     res.read_byte};
        if (expected_q.size() == 0) begin
          report_word("result word with nothing expected", 'x, got_word);
        end else begin
          want_word = expected_q.pop_front();
          if (got_word !== want_word) report_word("result word mismatch", want_word, got_word);
        end
      end
      if (cmd.valid && cmd.ready)
        expected_q.push_back(step_master(cmd.kind, cmd.write_byte, cmd.line_level));
    end
    outstanding = expected_q.size();
  end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import owtm_pkg::*;

  localparam int RANDOM_ITEMS = 900;
  localparam int TIMEOUT_NS = 1000000;

  // Ticks that carry each command from its start back to idle.
  localparam int TICKS_RESET = int'(WAIT_RST_HIGH) + int'(WAIT_RST_LOW) +
                               int'(WAIT_RST_SETTLE) + int'(WAIT_RST_TAIL);
  localparam int TICKS_WRITE = 1 + 8 * (int'(WAIT_SLOT_LOW) + int'(WAIT_WR_DATA) +
                                        int'(WAIT_WR_RECOV));
  localparam int TICKS_READ = 8 * (int'(WAIT_SLOT_LOW) + int'(WAIT_RD_SAMPLE) +
                                   int'(WAIT_RD_TAIL) + 1);

  // How the bus level is shown on tick words.
  localparam int LVL_LOW = 0;
  localparam int LVL_HIGH = 1;
  localparam int LVL_RANDOM = 2;

  logic clk = 1'b0;
  logic rst;
  int   fail_count;
  int   outstanding;
  int   burst_left;
  int   sent_words;
  int   rx_cycle = 0;
  int   rx_mode = 0;

  owtm_cmd_if cmd_if();
  owtm_res_if res_if();

  onewire_tick_driven_master u_dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_if),
    .res (res_if)
  );

  owtm_checker u_chk (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd_if),
    .res         (res_if),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Receiver back-pressure: ready follows one of four patterns, picked anew at random.
  always @(negedge clk) begin
    rx_cycle++;
    if (rx_cycle % 128 == 0) rx_mode = $urandom_range(0, 3);
    case (rx_mode)
      0: res_if.ready <= 1'b1;
      1: res_if.ready <= ($urandom_range(0, 3) != 0);
      2: res_if.ready <= (rx_cycle % 5 < 3);
      default: res_if.ready <= (rx_cycle % 16 >= 6);
    endcase
  end

  // Sends one command word; words go out in bursts with random idle gaps, possibly none, between them.
  task automatic send_word(input logic [1:0] kind, input logic [7:0] wb, input logic lvl);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(200, 600)
                                               : $urandom_range(1, 24);
      if (gap != 0) begin
        @(negedge clk);
        cmd_if.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    cmd_if.valid <= 1'b1;
    cmd_if.kind <= kind;
    cmd_if.write_byte <= wb;
    cmd_if.line_level <= lvl;
    @(posedge clk);
    while (!cmd_if.ready) @(posedge clk);
    burst_left--;
    sent_words++;
  endtask

  // Tick words; a noisy run slips in stray start commands now and then.
  task automatic tick_run(input int count, input int lvl_mode, input bit noisy);
    logic lvl;
    for (int i = 0; i < count; i++) begin
      lvl = (lvl_mode == LVL_LOW) ? 1'b0 :
            (lvl_mode == LVL_HIGH) ? 1'b1 : 1'($urandom_range(0, 1));
      if (noisy && $urandom_range(0, 39) == 0)
        send_word(2'($urandom_range(KIND_RESET, KIND_READ)), 8'($urandom),
                  1'($urandom_range(0, 1)));
      send_word(KIND_TICK, 8'($urandom), lvl);
    end
  endtask

  // One start command followed by enough ticks to bring the master back to idle.
  task automatic run_sequence(input logic [1:0] kind, input logic [7:0] wb,
                              input int lvl_mode, input bit noisy);
    int ticks;
    case (kind)
      KIND_RESET: ticks = TICKS_RESET;
      KIND_WRITE: ticks = TICKS_WRITE;
      default: ticks = TICKS_READ;
    endcase
    send_word(kind, wb, 1'($urandom_range(0, 1)));
    tick_run(ticks + $urandom_range(0, 3), lvl_mode, noisy);
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    cmd_if.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  initial begin
    int pick;
    rst = 1'b1;
    cmd_if.valid = 1'b0;
    cmd_if.kind = KIND_TICK;
    cmd_if.write_byte = 8'h00;
    cmd_if.line_level = 1'b0;
    res_if.ready = 1'b0;
    burst_left = 0;
    sent_words = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // A write before the first tick is taken while still not ready; starts of every
    // kind are then refused while it runs, and the trailing ticks land in idle.
    send_word(KIND_WRITE, 8'hFF, 1'b1);
    send_word(KIND_RESET, 8'h00, 1'b0);
    send_word(KIND_WRITE, 8'h00, 1'b1);
    send_word(KIND_READ, 8'h5A, 1'b0);
    tick_run(TICKS_WRITE + 3, LVL_RANDOM, 1'b0);
    run_sequence(KIND_WRITE, 8'h00, LVL_HIGH, 1'b0);

    // A device answers the bus reset; reads leave presence alone; the next reset clears it.
    run_sequence(KIND_RESET, 8'hFF, LVL_LOW, 1'b0);
    run_sequence(KIND_READ, 8'h00, LVL_HIGH, 1'b0);
    run_sequence(KIND_READ, 8'hFF, LVL_LOW, 1'b0);
    run_sequence(KIND_RESET, 8'h00, LVL_HIGH, 1'b0);
    run_sequence(KIND_READ, 8'h3C, LVL_RANDOM, 1'b0);
    run_sequence(KIND_WRITE, 8'hA5, LVL_RANDOM, 1'b0);

    // Let the master drain completely once before the random part.
    wait_for_results();

    // Random part: mostly whole transfers with random data, some stray words.
    sent_words = 0;
    while (sent_words < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 9);
      if (pick < 4) run_sequence(KIND_WRITE, 8'($urandom), LVL_RANDOM, 1'b1);
      else if (pick < 8) run_sequence(KIND_READ, 8'($urandom), LVL_RANDOM, 1'b1);
      else if (pick == 8) run_sequence(KIND_RESET, 8'($urandom), LVL_RANDOM, 1'b1);
      else tick_run($urandom_range(1, 8), LVL_RANDOM, 1'b1);
    end

    wait_for_results();
    repeat (8) @(negedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/owtm_pkg.sv
rtl/owtm_if.sv
rtl/onewire_tick_driven_master.sv
rtl/owtm_checker.sv
tb/sv/owtm_checker.sv
tb/sv/tb.sv
